// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define SAU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, held off during reset
`define SAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/sau_pkg.sv =====
// shared types and constants of the stack arithmetic unit
package sau_pkg;

    localparam int SAU_STACK_DEPTH  = 64;
    localparam int SAU_DATA_W       = 32;
    localparam int SAU_MIN_OPERANDS = 2;
    localparam int SAU_DEPTH_W      = 7;

    typedef enum logic [2:0] {
        KIND_PUSH = 3'd0,
        KIND_ADD  = 3'd1,
        KIND_SUB  = 3'd2,
        KIND_MUL  = 3'd3,
        KIND_DIV  = 3'd4,
        KIND_MOD  = 3'd5
    } sau_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_DIVZ  = 2'd2,
        STATUS_FULL  = 2'd3
    } sau_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIVIDE,
        ST_RESULT
    } sau_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic div_start;
        logic div_take;
        logic commit;
    } sau_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_op;
        logic div_done;
    } sau_stat_t;

endpackage

// ===== design/sau_ram.sv =====
// generic single-write, single-read memory with registered read data
module sau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sau_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module sau_div
    import sau_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SAU_DATA_W-1:0] dividend,
    input  logic [SAU_DATA_W-1:0] divisor,
    output logic                  done,
    output logic [SAU_DATA_W-1:0] quotient,
    output logic [SAU_DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(SAU_DATA_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SAU_DATA_W-1:0] rem_reg, rem_next;
    logic [SAU_DATA_W-1:0] quo_reg, quo_next;
    logic [SAU_DATA_W-1:0] dvs_reg, dvs_next;
    logic                  qneg_reg, qneg_next;
    logic                  rneg_reg, rneg_next;

    logic [SAU_DATA_W:0]   shifted;
    logic [SAU_DATA_W:0]   diff;
    logic                  a_neg, b_neg;

    assign a_neg   = dividend[SAU_DATA_W-1];
    assign b_neg   = divisor[SAU_DATA_W-1];
    assign shifted = {rem_reg, quo_reg[SAU_DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SAU_DATA_W);
            rem_next  = '0;
            quo_next  = a_neg ? (SAU_DATA_W'(0) - dividend) : dividend;
            dvs_next  = b_neg ? (SAU_DATA_W'(0) - divisor) : divisor;
            qneg_next = a_neg ^ b_neg;
            rneg_next = a_neg;
        end else if (busy_reg) begin
            // restoring step: keep the difference when it did not go negative
            if (!diff[SAU_DATA_W]) begin
                rem_next = diff[SAU_DATA_W-1:0];
                quo_next = {quo_reg[SAU_DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[SAU_DATA_W-1:0];
                quo_next = {quo_reg[SAU_DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (SAU_DATA_W'(0) - quo_reg) : quo_reg;
    assign remainder = rneg_reg ? (SAU_DATA_W'(0) - rem_reg) : rem_reg;

endmodule

// ===== design/sau_ctrl.sv =====
// sequencing state machine and result-valid flag
module sau_ctrl
    import sau_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  sau_stat_t stat,
    output sau_cmd_t  cmd
);

    sau_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                if (stat.div_op) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== design/sau_dpath.sv =====
// operand stack, cached top entry, alu, divider and result registers
module sau_dpath
    import sau_pkg::*;
#(
    parameter int STACK_DEPTH = SAU_STACK_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sau_cmd_t               cmd,
    output sau_stat_t              stat,
    input  logic [2:0]             s_kind,
    input  logic [SAU_DATA_W-1:0]  s_push_value,
    output logic [1:0]             m_status,
    output logic [SAU_DATA_W-1:0]  m_top_value,
    output logic [SAU_DEPTH_W-1:0] m_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [2:0]             kind_reg;
    logic [SAU_DATA_W-1:0]  push_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [SAU_DATA_W-1:0]  top_reg, top_next;
    logic [SAU_DATA_W-1:0]  res_reg;
    logic [1:0]             status_reg;
    logic                   apply_reg;
    logic [1:0]             m_status_reg;
    logic [SAU_DATA_W-1:0]  m_top_reg;
    logic [SAU_DEPTH_W-1:0] m_depth_reg;

    logic [SAU_DATA_W-1:0]  second;
    logic [SAU_DATA_W-1:0]  alu_res;
    logic [SAU_DATA_W-1:0]  mul_lo;
    logic [1:0]             calc_status;
    logic                   is_full, is_short, is_zero;
    logic [CW-1:0]          below_two;
    logic [AW-1:0]          second_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   div_done;
    logic [SAU_DATA_W-1:0]  div_q, div_r;

    assign below_two   = count_reg - CW'(SAU_MIN_OPERANDS);
    assign second_addr = below_two[AW-1:0];
    assign is_full     = (count_reg == CW'(STACK_DEPTH));
    assign is_short    = (count_reg < CW'(SAU_MIN_OPERANDS));
    assign is_zero     = (top_reg == '0);
    assign mul_lo      = second * top_reg;

    // second entry is read continuously; data is ready in the cycle after accept
    sau_ram #(
        .WIDTH (SAU_DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (res_reg),
        .rd_addr (second_addr),
        .rd_data (second)
    );

    sau_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (second),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        calc_status = STATUS_OK;
        alu_res     = push_reg;
        case (kind_reg)
            KIND_PUSH: begin
                calc_status = is_full ? STATUS_FULL : STATUS_OK;
            end
            KIND_ADD: begin
                calc_status = is_short ? STATUS_SHORT : STATUS_OK;
                alu_res     = second + top_reg;
            end
            KIND_SUB: begin
                calc_status = is_short ? STATUS_SHORT : STATUS_OK;
                alu_res     = second - top_reg;
            end
            KIND_MUL: begin
                calc_status = is_short ? STATUS_SHORT : STATUS_OK;
                alu_res     = mul_lo;
            end
            KIND_DIV, KIND_MOD: begin
                calc_status = is_short ? STATUS_SHORT :
                              (is_zero ? STATUS_DIVZ : STATUS_OK);
            end
            default: begin
                calc_status = STATUS_OK;
            end
        endcase
    end

    assign stat.div_op   = ((kind_reg == KIND_DIV) || (kind_reg == KIND_MOD)) &&
                           (calc_status == STATUS_OK);
    assign stat.div_done = div_done;

    // stack update applied on commit
    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_addr    = second_addr;
        if (cmd.commit && apply_reg) begin
            wr_en    = 1'b1;
            top_next = res_reg;
            if (kind_reg == KIND_PUSH) begin
                wr_addr    = count_reg[AW-1:0];
                count_next = count_reg + CW'(1);
            end else begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        top_reg <= top_next;
        if (cmd.load) begin
            kind_reg <= s_kind;
            push_reg <= s_push_value;
        end
        if (cmd.calc) begin
            res_reg    <= alu_res;
            status_reg <= calc_status;
            apply_reg  <= (calc_status == STATUS_OK) && (kind_reg <= KIND_MOD);
        end else if (cmd.div_take) begin
            res_reg <= (kind_reg == KIND_DIV) ? div_q : div_r;
        end
        if (cmd.commit) begin
            m_status_reg <= status_reg;
            m_top_reg    <= (count_next != '0) ? top_next : '0;
            m_depth_reg  <= SAU_DEPTH_W'(count_next);
        end
    end

    assign m_status    = m_status_reg;
    assign m_top_value = m_top_reg;
    assign m_depth     = m_depth_reg;

endmodule

// ===== design/stack_arithmetic_unit_core.sv =====
// stack arithmetic unit: top level joining the controller and the datapath
//
// A bounded stack of 32-bit signed entries with a small alu. Each input beat
// is either a push of s_push_value or a binary operation (add, sub, mul, div,
// mod) that pops the top t and the second entry s and pushes s op t; add, sub
// and mul wrap, div and mod truncate toward zero with the remainder taking
// the dividend's sign. Every input beat yields exactly one result beat with
// a status (ok, stack too short, division by zero, stack full), the top entry
// afterwards (zero when empty) and the depth afterwards. On any error the
// stack is left as it was. Kinds six and seven do nothing and report ok.
// One item is in flight at a time. A push, add, sub, mul or spare kind,
// and any item that ends in an error, goes from accept through operate and
// commit to the result register; a div or mod that divides also passes
// through the divider between start and hand-over, and the divider yields
// one quotient bit per cycle. The next beat is taken as soon as the result
// is committed, even while that result still waits on m_ready; commit of a
// following item then waits for the result register.
// The stack lives in a memory of STACK_DEPTH entries with the top entry also
// kept in a register, so only the second entry is ever read from memory.
// No clearing pass runs after reset: entries are only used once written.
module stack_arithmetic_unit_core
    import sau_pkg::*;
#(
    parameter int STACK_DEPTH = SAU_STACK_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_kind,
    input  logic signed [SAU_DATA_W-1:0]  s_push_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic signed [SAU_DATA_W-1:0]  m_top_value,
    output logic [SAU_DEPTH_W-1:0]        m_depth
);

    sau_cmd_t              cmd;
    sau_stat_t             stat;
    logic [SAU_DATA_W-1:0] top_value;

    // sequencing: accept, operate, optional divide, commit
    sau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // stack memory, cached top, alu, divider and the result register
    sau_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_kind       (s_kind),
        .s_push_value ($unsigned(s_push_value)),
        .m_status     (m_status),
        .m_top_value  (top_value),
        .m_depth      (m_depth)
    );

    assign m_top_value = $signed(top_value);

endmodule

// ===== design/sau_checker.sv =====
// port-level checks of the stack arithmetic unit, bound to the top level
`include "assert_macros.svh"

module sau_checker
    import sau_pkg::*;
#(
    parameter int STACK_DEPTH = SAU_STACK_DEPTH
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [2:0]                    s_kind,
    input logic signed [SAU_DATA_W-1:0]  s_push_value,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic signed [SAU_DATA_W-1:0]  m_top_value,
    input logic [SAU_DEPTH_W-1:0]        m_depth
);

    logic [SAU_DATA_W+2:0]             in_beat;
    logic [SAU_DATA_W+SAU_DEPTH_W+1:0] out_beat;

    assign in_beat  = {s_kind, s_push_value};
    assign out_beat = {m_status, m_top_value, m_depth};

    // a waiting input beat holds
    `SAU_ASSERT_NEXT(a_input_held, s_valid && !s_ready, s_valid && $stable(in_beat))

    // a stalled result beat holds
    `SAU_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(out_beat))

    // a refused push only happens on a full stack
    `SAU_ASSERT_NOW(a_full_depth, m_valid && (m_status == STATUS_FULL), m_depth == SAU_DEPTH_W'(STACK_DEPTH))

    // too short means fewer than two entries remain
    `SAU_ASSERT_NOW(a_short_depth, m_valid && (m_status == STATUS_SHORT), m_depth < SAU_DEPTH_W'(SAU_MIN_OPERANDS))

    // a zero divisor stays on top
    `SAU_ASSERT_NOW(a_divz_top, m_valid && (m_status == STATUS_DIVZ), m_top_value == '0)

endmodule

bind stack_arithmetic_unit_core sau_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_sau_checker (.*);
